>>> src/pss_pkg.sv
// Shared types and constants for the plucked string synthesizer.
package pss_pkg;

    localparam int LEN_W      = 13;
    localparam int DLY_W      = 20;
    localparam int BETA_W     = 17;
    localparam int SMP_W      = 16;
    localparam int SPAN_W     = 21;
    localparam int POS_W      = 22;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 18;
    localparam int ACC_W      = 35;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int FRAC_W     = 8;

    localparam logic [BETA_W-1:0] BETA_ONE   = 17'h10000;
    localparam logic [BETA_W-1:0] BETA_RESET = 17'h08000;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POS,
        ST_WRAP,
        ST_RDA,
        ST_RDB,
        ST_MACB,
        ST_RND,
        ST_MUL3,
        ST_MUL4,
        ST_WR,
        ST_ZERO
    } t_state;

endpackage

>>> src/plucked_string_synth_core.sv
// Karplus-Strong string voice: delay line memory, sequencer and one shared multiplier.
// A load beat is written into the delay line in the idle state. A tick beat runs through states
// POS, WRAP, RDA, RDB, MACB, RND, MUL3, MUL4 and WR to the result register before the next beat
// is taken, set by the single-port delay line and the one multiplier used four times. On a
// zero-length line a tick goes to the ZERO state and gives a zero result. A full result register
// holds a tick in its last step. After reset a clearing pass zeros all MAX_LENGTH entries, one
// per cycle, before the first input beat is taken; configuration writes are taken throughout.
module plucked_string_synth_core #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [pss_pkg::SMP_W-1:0]         i_s_axis_tdata,  // [15:0] excitation
    input  logic                              i_s_axis_tuser,  // [0] kind
    // Output stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [pss_pkg::SMP_W-1:0]         o_m_axis_tdata   // [15:0] sample
);
    import pss_pkg::*;

    localparam int PW = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;

    t_state r_state, n_state;

    logic [SMP_W-1:0]  r_mem [MAX_LENGTH];
    logic [SMP_W-1:0]  r_rd_data;

    logic [LEN_W-1:0]  r_cfg_len;
    logic [DLY_W-1:0]  r_cfg_dly;
    logic [BETA_W-1:0] r_cfg_beta;

    logic [PW-1:0]     r_ptr;
    logic [PW-1:0]     r_clr;
    logic [PW-1:0]     r_j;
    logic [LEN_W-1:0]  r_len;
    logic [SPAN_W-1:0] r_dly;
    logic [SPAN_W-1:0] r_p;
    logic [SMP_W-1:0]  r_r;
    logic [SMP_W-1:0]  r_prev;
    logic signed [ACC_W-1:0] r_acc;
    logic              r_out_valid;
    logic [SMP_W-1:0]  r_out_data;

    logic              in_accept;
    logic              out_free;
    logic              clr_done;
    logic [LEN_W-1:0]  len_eff;
    logic [PW-1:0]     ptr_norm;
    logic [PW-1:0]     ptr_next;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] dly_clamp;
    logic [POS_W-1:0]  pos_raw;
    logic [POS_W-1:0]  pos_wrap;
    logic [PW-1:0]     idx_a;
    logic [31:0]       idx_a_inc;
    logic [BETA_W-1:0] beta_c;

    logic              mem_we;
    logic [PW-1:0]     mem_addr;
    logic [SMP_W-1:0]  mem_wdata;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   rnd_r;
    logic signed [ACC_W-1:0]   rnd_v;

    // ---------------------------------------------------------------- datapath helpers
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign clr_done  = (32'(r_clr) == 32'(MAX_LENGTH - 1));

    assign len_eff  = ({19'b0, r_cfg_len} > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : r_cfg_len;
    assign ptr_norm = (32'(r_ptr) >= 32'(len_eff)) ? '0 : r_ptr;
    assign ptr_next = (32'(ptr_norm) + 32'd1 == 32'(len_eff)) ? '0
                                                              : PW'(32'(ptr_norm) + 32'd1);

    assign span      = {r_len, {FRAC_W{1'b0}}};
    assign dly_clamp = ({1'b0, r_cfg_dly} >= span) ? span - SPAN_W'(1) : {1'b0, r_cfg_dly};
    assign pos_raw   = (POS_W'(r_ptr) << FRAC_W) - POS_W'(r_dly);
    // A negative position has its top bit set, since both terms are below the span.
    assign pos_wrap  = pos_raw[POS_W-1] ? pos_raw + POS_W'(span) : pos_raw;
    assign idx_a     = PW'(r_p >> FRAC_W);
    assign idx_a_inc = 32'(idx_a) + 32'd1;

    assign beta_c = (r_cfg_beta > BETA_ONE) ? BETA_ONE : r_cfg_beta;

    assign prod  = mul_a * mul_b;
    assign rnd_r = r_acc + ACC_W'(128);
    assign rnd_v = r_acc + ACC_W'(32768);

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (clr_done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_accept && i_s_axis_tuser == KIND_TICK) begin
                    n_state = (len_eff == '0) ? ST_ZERO : ST_POS;
                end
            end
            ST_POS:  n_state = ST_WRAP;
            ST_WRAP: n_state = ST_RDA;
            ST_RDA:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_MACB;
            ST_MACB: n_state = ST_RND;
            ST_RND:  n_state = ST_MUL3;
            ST_MUL3: n_state = ST_MUL4;
            ST_MUL4: n_state = ST_WR;
            ST_WR:   if (out_free) n_state = ST_IDLE;
            ST_ZERO: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = r_ptr;
        mem_wdata = '0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                mem_addr  = ptr_norm;
                mem_wdata = i_s_axis_tdata;
                mem_we    = in_accept && (i_s_axis_tuser == KIND_LOAD) && (len_eff != '0);
            end
            ST_RDA:  mem_addr = idx_a;
            ST_RDB: begin
                mem_addr = r_j;
                mul_a    = {r_rd_data[SMP_W-1], r_rd_data};
                mul_b    = MUL_B_W'(9'd256 - {1'b0, r_p[FRAC_W-1:0]});
            end
            ST_MACB: begin
                mul_a = {r_rd_data[SMP_W-1], r_rd_data};
                mul_b = MUL_B_W'(r_p[FRAC_W-1:0]);
            end
            ST_MUL3: begin
                mul_a = {r_r[SMP_W-1], r_r};
                mul_b = MUL_B_W'(beta_c);
            end
            ST_MUL4: begin
                mul_a = {r_prev[SMP_W-1], r_prev};
                mul_b = MUL_B_W'(BETA_ONE - beta_c);
            end
            ST_WR: begin
                mem_we    = out_free;
                mem_wdata = rnd_v[16 +: SMP_W];
            end
            ST_POS, ST_WRAP, ST_RND, ST_ZERO: begin
                mem_we = 1'b0;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- delay line memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_ptr       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
            r_cfg_len   <= '0;
            r_cfg_dly   <= '0;
            r_cfg_beta  <= BETA_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + PW'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_LINE_LENGTH:   r_cfg_len  <= i_cfg_data[LEN_W-1:0];
                    REG_DELAY_SAMPLES: r_cfg_dly  <= i_cfg_data[DLY_W-1:0];
                    REG_BLEND_WEIGHT:  r_cfg_beta <= i_cfg_data[BETA_W-1:0];
                    default:           r_cfg_len  <= r_cfg_len;
                endcase
            end
            if (r_state == ST_IDLE && in_accept && len_eff != '0) begin
                r_ptr <= (i_s_axis_tuser == KIND_LOAD) ? ptr_next : ptr_norm;
            end
            if (r_state == ST_WR && out_free) begin
                r_prev <= r_r;
                r_ptr  <= (32'(r_ptr) + 32'd1 == 32'(r_len)) ? '0 : r_ptr + PW'(1);
            end
            if ((r_state == ST_WR || r_state == ST_ZERO) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_len <= len_eff;
        end
        if (r_state == ST_POS) begin
            r_dly <= dly_clamp;
        end
        if (r_state == ST_WRAP) begin
            r_p <= pos_wrap[SPAN_W-1:0];
        end
        if (r_state == ST_RDA) begin
            r_j <= (idx_a_inc == 32'(r_len)) ? '0 : PW'(idx_a_inc);
        end
        if (r_state == ST_RDB || r_state == ST_MUL3) begin
            r_acc <= prod;
        end else if (r_state == ST_MACB || r_state == ST_MUL4) begin
            r_acc <= r_acc + prod;
        end
        if (r_state == ST_RND) begin
            r_r <= rnd_r[FRAC_W +: SMP_W];
        end
        if (r_state == ST_WR && out_free) begin
            r_out_data <= rnd_v[16 +: SMP_W];
        end else if (r_state == ST_ZERO && out_free) begin
            r_out_data <= '0;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------- assertions
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR && out_free) |=> (32'(r_ptr) < 32'(r_len)))
        else $error("write pointer left the active line after a tick");

    a_pos_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDA) |-> ({11'b0, r_p} < {11'b0, r_len, 8'b0}))
        else $error("wrapped read position outside the delay line");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == ST_WR || $past(r_state) == ST_ZERO))
        else $error("result appeared without a finished tick");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && !clr_done) |=> (r_state == ST_CLEAR))
        else $error("clearing pass ended early");

endmodule
